[rtl/triangle_plane_clipper_macros.svh]
// Assertion macros for the triangle plane clipper.
`ifndef TRIANGLE_PLANE_CLIPPER_MACROS_SVH
`define TRIANGLE_PLANE_CLIPPER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TPC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("triangle_plane_clipper: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TPC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("triangle_plane_clipper: next-cycle check failed");

`endif

[rtl/tpc_pkg.sv]
// Shared widths, types and helpers of the triangle plane clipper.
package tpc_pkg;

  localparam int COORD_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int T_BITS      = 32;
  localparam int DIST_W      = 2 * COORD_BITS + 2;
  localparam int REM_W       = DIST_W + 2;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = DIFF_W + T_BITS + 1;
  localparam int OFF_W       = PROD_W - T_BITS;
  localparam int SUM_W       = OFF_W + 1;
  localparam int NUM_STAGES  = T_BITS + 6;
  localparam int LANE_STAGES = T_BITS + 2;
  localparam int CFG_IDX_W   = 2;
  localparam int TDATA_W     = 9 * COORD_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_NX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NZ  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vert_t;

  typedef struct packed {
    vert_t a;
    vert_t b;
    vert_t c;
  } tri_t;

  typedef enum logic [1:0] {
    CC_DROP,
    CC_PASS,
    CC_TWO_OUT,
    CC_ONE_OUT
  } clip_case_t;

  typedef struct packed {
    tri_t       v;
    clip_case_t cc;
    logic [1:0] idx;
  } item_t;

  typedef struct packed {
    logic [REM_W-1:0] din;
    logic [REM_W-1:0] den;
    vert_t            pin;
    vert_t            pout;
    logic             zero;
  } lane_setup_t;

  function automatic vert_t pick_vert(tri_t t, logic [1:0] i);
    vert_t r;
    case (i)
      2'd0:    r = t.a;
      2'd1:    r = t.b;
      default: r = t.c;
    endcase
    return r;
  endfunction

endpackage

[rtl/tpc_edge_lane.sv]
// One edge-point lane: restoring divider stages, scale multiply, offset add and saturation.
module tpc_edge_lane (
  input  logic                                clk,
  input  tpc_pkg::lane_setup_t                setup,
  input  logic [tpc_pkg::LANE_STAGES-1:0]     en,
  output tpc_pkg::vert_t                      edge_pt
);
  import tpc_pkg::*;

  typedef struct packed {
    vert_t pin;
    vert_t pout;
    logic  zero;
  } carry_t;

  logic [REM_W-1:0]  rem_r [T_BITS];
  logic [REM_W-1:0]  den_r [T_BITS];
  logic [T_BITS-1:0] quo_r [T_BITS];
  carry_t            car_r [T_BITS];

  // One quotient bit per stage
  for (genvar j = 0; j < T_BITS; j++) begin : g_div
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  den_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  rem_nxt;
    logic [T_BITS-1:0] quo_in;
    carry_t            car_in;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in = setup.din;
      assign den_in = setup.den;
      assign quo_in = '0;
      assign car_in = '{pin: setup.pin, pout: setup.pout, zero: setup.zero};
    end else begin : g_rest
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
      assign car_in = car_r[j-1];
    end

    assign rem_sh  = {rem_in[REM_W-2:0], 1'b0};
    assign ge      = (rem_sh >= den_in);
    assign rem_nxt = ge ? (rem_sh - den_in) : rem_sh;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt;
        den_r[j] <= den_in;
        quo_r[j] <= {quo_in[T_BITS-2:0], ge};
        car_r[j] <= car_in;
      end
    end
  end

  // Scale the edge vector by the quotient
  logic signed [DIFF_W-1:0] diff [3];
  logic signed [PROD_W-1:0] prod_r [3];
  carry_t                   mc_r;
  coord_t                   din_c [3];
  coord_t                   dout_c [3];

  assign din_c[0]  = car_r[T_BITS-1].pin.x;
  assign din_c[1]  = car_r[T_BITS-1].pin.y;
  assign din_c[2]  = car_r[T_BITS-1].pin.z;
  assign dout_c[0] = car_r[T_BITS-1].pout.x;
  assign dout_c[1] = car_r[T_BITS-1].pout.y;
  assign dout_c[2] = car_r[T_BITS-1].pout.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFF_W'($signed(dout_c[i])) - DIFF_W'($signed(din_c[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[T_BITS]) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= PROD_W'(diff[i] * $signed({1'b0, quo_r[T_BITS-1]}));
      end
      mc_r <= car_r[T_BITS-1];
    end
  end

  // Add the floored offset and clamp to the coordinate range
  coord_t pin_c [3];
  coord_t pout_c [3];
  coord_t res [3];
  vert_t  edge_r;

  assign pin_c[0]  = mc_r.pin.x;
  assign pin_c[1]  = mc_r.pin.y;
  assign pin_c[2]  = mc_r.pin.z;
  assign pout_c[0] = mc_r.pout.x;
  assign pout_c[1] = mc_r.pout.y;
  assign pout_c[2] = mc_r.pout.z;

  always_comb begin
    logic signed [OFF_W-1:0] off;
    logic signed [SUM_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      off = $signed(prod_r[i][PROD_W-1:T_BITS]);
      sum = SUM_W'($signed(pin_c[i])) + SUM_W'(off);
      if (mc_r.zero) begin
        res[i] = pout_c[i];
      end else if ((&sum[SUM_W-1:COORD_BITS-1]) || !(|sum[SUM_W-1:COORD_BITS-1])) begin
        res[i] = sum[COORD_BITS-1:0];
      end else if (sum[SUM_W-1]) begin
        res[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
        res[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[T_BITS+1]) begin
      edge_r <= '{x: res[0], y: res[1], z: res[2]};
    end
  end

  assign edge_pt = edge_r;

endmodule

[rtl/triangle_plane_clipper.sv]
// Top level of the triangle plane clipper: distance, classify, edge lanes and result output.
//
// Clips one triangle per input request against the plane n.p + d held in four
// registers written through the cfg_ port (index 0..3: normal x, y, z, offset).
// in_tdata carries the three vertices, out_tdata one result triangle, out_tlast
// marks the final triangle produced for an input. A triangle wholly outside
// produces nothing, a kept or one-triangle clip produces one request and a
// quad clip produces two requests, one after the other.
// The pipeline has 38 stages (input, products, distance sum, classify,
// 32 divider stages, scale, add) followed by the output register.
// It takes one input per cycle while the output is not stalled; an input that
// yields two triangles holds the output register until both are taken, so
// the output port then holds back the input.
// Every stage has a valid bit and moves when the stage after it is empty or
// moving, so bubbles close up and input is taken while a result waits.
// A stalled receiver holds out_tdata and out_tlast steady until taken.
// Reset clears all valid bits and loads the plane registers with normal
// (0, 0, 1.0) and offset 0.
`include "triangle_plane_clipper_macros.svh"

module triangle_plane_clipper (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [tpc_pkg::TDATA_W-1:0]          in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z, out_c_x, out_c_y, out_c_z
  output logic [tpc_pkg::TDATA_W-1:0]          out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tpc_pkg::COORD_BITS-1:0]       cfg_data
);
  import tpc_pkg::*;

  localparam int NS = NUM_STAGES;

  // Plane registers
  logic signed [COORD_BITS-1:0] nx_r, ny_r, nz_r, off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= COORD_BITS'(1) << FRAC_BITS;
      off_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NX:  nx_r  <= cfg_data;
        REG_NY:  ny_r  <= cfg_data;
        REG_NZ:  nz_r  <= cfg_data;
        REG_OFF: off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  item_t         it_r [NS];
  logic          em_free;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || em_free;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Unpack the input request
  tri_t in_tri;
  assign in_tri.a = '{x: in_tdata[0*COORD_BITS +: COORD_BITS],
                      y: in_tdata[1*COORD_BITS +: COORD_BITS],
                      z: in_tdata[2*COORD_BITS +: COORD_BITS]};
  assign in_tri.b = '{x: in_tdata[3*COORD_BITS +: COORD_BITS],
                      y: in_tdata[4*COORD_BITS +: COORD_BITS],
                      z: in_tdata[5*COORD_BITS +: COORD_BITS]};
  assign in_tri.c = '{x: in_tdata[6*COORD_BITS +: COORD_BITS],
                      y: in_tdata[7*COORD_BITS +: COORD_BITS],
                      z: in_tdata[8*COORD_BITS +: COORD_BITS]};

  // Stage 1: normal products
  logic signed [2*COORD_BITS-1:0] pr_r [3][3];
  vert_t                          s0_v [3];

  assign s0_v[0] = it_r[0].v.a;
  assign s0_v[1] = it_r[0].v.b;
  assign s0_v[2] = it_r[0].v.c;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        pr_r[i][0] <= $signed(s0_v[i].x) * nx_r;
        pr_r[i][1] <= $signed(s0_v[i].y) * ny_r;
        pr_r[i][2] <= $signed(s0_v[i].z) * nz_r;
      end
    end
  end

  // Stage 2: signed distances
  logic signed [DIST_W-1:0] dist_r [3];
  logic signed [DIST_W-1:0] off_term;

  assign off_term = DIST_W'(off_r) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        dist_r[i] <= DIST_W'(pr_r[i][0]) + DIST_W'(pr_r[i][1]) + DIST_W'(pr_r[i][2])
                     + off_term;
      end
    end
  end

  // Stage 3: classify and set up both edge lanes
  logic [2:0]  outside;
  logic [1:0]  n_out;
  clip_case_t  cc;
  logic [1:0]  cidx, i0, o0, i1, o1;
  lane_setup_t setup_nxt [2];
  lane_setup_t setup_r [2];

  function automatic logic signed [DIST_W-1:0] pick_dist(logic signed [DIST_W-1:0] d0,
                                                         logic signed [DIST_W-1:0] d1,
                                                         logic signed [DIST_W-1:0] d2,
                                                         logic [1:0] i);
    logic signed [DIST_W-1:0] r;
    case (i)
      2'd0:    r = d0;
      2'd1:    r = d1;
      default: r = d2;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      outside[i] = dist_r[i][DIST_W-1] || (dist_r[i] == '0);
    end
    n_out = {1'b0, outside[0]} + {1'b0, outside[1]} + {1'b0, outside[2]};
    cc   = CC_PASS;
    cidx = 2'd0;
    i0 = 2'd0; o0 = 2'd1; i1 = 2'd0; o1 = 2'd2;
    case (n_out)
      2'd0: cc = CC_PASS;
      2'd1: begin
        cc   = CC_ONE_OUT;
        cidx = outside[0] ? 2'd0 : (outside[1] ? 2'd1 : 2'd2);
        i0   = (cidx == 2'd0) ? 2'd1 : 2'd0;
        o0   = cidx;
        i1   = (cidx == 2'd2) ? 2'd1 : 2'd2;
        o1   = cidx;
      end
      2'd2: begin
        cc   = CC_TWO_OUT;
        cidx = !outside[0] ? 2'd0 : (!outside[1] ? 2'd1 : 2'd2);
        i0   = cidx;
        o0   = (cidx == 2'd0) ? 2'd1 : 2'd0;
        i1   = cidx;
        o1   = (cidx == 2'd2) ? 2'd1 : 2'd2;
      end
      default: cc = CC_DROP;
    endcase
  end

  always_comb begin
    logic signed [DIST_W-1:0] di, dq;
    logic [1:0] li, lo;
    for (int l = 0; l < 2; l++) begin
      li = (l == 0) ? i0 : i1;
      lo = (l == 0) ? o0 : o1;
      di = pick_dist(dist_r[0], dist_r[1], dist_r[2], li);
      dq = pick_dist(dist_r[0], dist_r[1], dist_r[2], lo);
      setup_nxt[l].din  = REM_W'(di);
      setup_nxt[l].den  = REM_W'(di) - REM_W'(dq);
      setup_nxt[l].pin  = pick_vert(it_r[2].v, li);
      setup_nxt[l].pout = pick_vert(it_r[2].v, lo);
      setup_nxt[l].zero = (dq == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      setup_r[0] <= setup_nxt[0];
      setup_r[1] <= setup_nxt[1];
    end
  end

  // Carry the item along every stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      it_r[0] <= '{v: in_tri, cc: CC_DROP, idx: 2'd0};
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        if (k == 3) begin
          it_r[k] <= '{v: it_r[k-1].v, cc: cc, idx: cidx};
        end else begin
          it_r[k] <= it_r[k-1];
        end
      end
    end
  end

  // Edge lanes
  vert_t e0, e1;

  tpc_edge_lane u_lane0 (
    .clk     (clk),
    .setup   (setup_r[0]),
    .en      (en[NS-1:4]),
    .edge_pt (e0)
  );

  tpc_edge_lane u_lane1 (
    .clk     (clk),
    .setup   (setup_r[1]),
    .en      (en[NS-1:4]),
    .edge_pt (e1)
  );

  // Assemble result triangles
  item_t last_it;
  tri_t  t0_nxt, t1_nxt;
  logic  two_nxt, has_nxt;

  assign last_it = it_r[NS-1];

  always_comb begin
    t0_nxt  = last_it.v;
    t1_nxt  = last_it.v;
    two_nxt = 1'b0;
    has_nxt = 1'b1;
    case (last_it.cc)
      CC_PASS: ;
      CC_TWO_OUT: t0_nxt = '{a: pick_vert(last_it.v, last_it.idx), b: e0, c: e1};
      CC_ONE_OUT: begin
        two_nxt = 1'b1;
        case (last_it.idx)
          2'd0: begin
            t0_nxt = '{a: e0, b: e1, c: last_it.v.b};
            t1_nxt = '{a: last_it.v.c, b: e1, c: last_it.v.b};
          end
          2'd1: begin
            t0_nxt = '{a: e0, b: e1, c: last_it.v.c};
            t1_nxt = '{a: last_it.v.a, b: e0, c: last_it.v.c};
          end
          default: begin
            t0_nxt = '{a: e0, b: e1, c: last_it.v.a};
            t1_nxt = '{a: last_it.v.b, b: e1, c: last_it.v.a};
          end
        endcase
      end
      default: has_nxt = 1'b0;
    endcase
  end

  // Output register: hold up to two triangles, send in order
  logic em_v_r, em_ph_r, em_two_r;
  tri_t tri0_r, tri1_r, cur;
  logic out_fire;

  assign out_tvalid = em_v_r;
  assign out_tlast  = em_ph_r || !em_two_r;
  assign out_fire   = out_tvalid && out_tready;
  assign em_free    = !em_v_r || (out_fire && out_tlast);
  assign cur        = em_ph_r ? tri1_r : tri0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r  <= 1'b0;
      em_ph_r <= 1'b0;
    end else if (em_free) begin
      em_v_r  <= v_r[NS-1] && has_nxt;
      em_ph_r <= 1'b0;
    end else if (out_fire) begin
      em_ph_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (em_free) begin
      tri0_r   <= t0_nxt;
      tri1_r   <= t1_nxt;
      em_two_r <= two_nxt;
    end
  end

  assign out_tdata = {cur.c.z, cur.c.y, cur.c.x,
                      cur.b.z, cur.b.y, cur.b.x,
                      cur.a.z, cur.a.y, cur.a.x};

  // Checks
  `TPC_ASSERT_NEXT(a_second_follows, out_fire && !out_tlast, out_tvalid && out_tlast)
  `TPC_ASSERT_NOW(a_empty_head_ready, !v_r[0], in_tready)
  `TPC_ASSERT_NEXT(a_tail_holds, v_r[NS-1] && !en[NS-1], v_r[NS-1])

endmodule

[tb/sv/triangle_plane_clipper_tb.sv]
// Testbench for the triangle plane clipper: directed and random triangles with a scoreboard.
module triangle_plane_clipper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;

  typedef logic signed [127:0] wide_t;
  typedef logic [95:0] vtx_t;

  typedef struct {
    logic [TDATA_W-1:0] tri_data;
    logic               last;
  } clip_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  logic [TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z, out_c_x, out_c_y, out_c_z
  logic [TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_BITS-1:0] cfg_data;

  // plane held by the predictor
  longint plane_nx, plane_ny, plane_nz, plane_d;
  clip_result_t expected_tris[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int quiet_cycles;

  triangle_plane_clipper i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // pack three coordinates, x in the lowest bits
  function automatic vtx_t pack_vtx(longint p[3]);
    return {32'(p[2]), 32'(p[1]), 32'(p[0])};
  endfunction

  function automatic wide_t plane_distance(longint p[3]);
    return wide_t'(plane_nx) * wide_t'(p[0]) + wide_t'(plane_ny) * wide_t'(p[1])
         + wide_t'(plane_nz) * wide_t'(p[2]) + (wide_t'(plane_d) <<< FRAC_BITS);
  endfunction

  // point on the edge from inside end toward outside end, floored steps
  function automatic vtx_t edge_point(longint pin[3], longint pout[3], wide_t din,
                                      wide_t dout);
    wide_t den;
    wide_t frac;
    wide_t v;
    longint r[3];
    den = din - dout;
    if (dout == 0) return pack_vtx(pout);
    frac = (din <<< T_BITS) / den;
    for (int i = 0; i < 3; i++) begin
      v = wide_t'(pin[i]) + ((wide_t'(pout[i] - pin[i]) * frac) >>> T_BITS);
      if (v < -wide_t'(64'sd2147483648)) v = -wide_t'(64'sd2147483648);
      else if (v > wide_t'(64'sd2147483647)) v = wide_t'(64'sd2147483647);
      r[i] = longint'(v);
    end
    return pack_vtx(r);
  endfunction

  function automatic void push_tri(vtx_t a, vtx_t b, vtx_t c, logic last);
    clip_result_t res;
    res.tri_data = {c, b, a};
    res.last = last;
    expected_tris = {expected_tris, res};
  endfunction

  // expected triangles for one input triangle
  function automatic void clip_triangle(logic [TDATA_W-1:0] tri_in);
    longint v0[3], v1[3], v2[3];
    wide_t d[3];
    bit outside[3];
    int n_out;
    vtx_t e0, e1;
    n_out = 0;
    for (int j = 0; j < 3; j++) begin
      v0[j] = longint'(signed'(tri_in[32*j +: 32]));
      v1[j] = longint'(signed'(tri_in[32*(3+j) +: 32]));
      v2[j] = longint'(signed'(tri_in[32*(6+j) +: 32]));
    end
    d[0] = plane_distance(v0);
    d[1] = plane_distance(v1);
    d[2] = plane_distance(v2);
    for (int i = 0; i < 3; i++) begin
      outside[i] = d[i] <= 0;
      n_out += outside[i];
    end
    if (n_out == 0) begin
      push_tri(pack_vtx(v0), pack_vtx(v1), pack_vtx(v2), 1'b1);
    end else if (n_out == 2) begin
      if (!outside[0]) begin
        push_tri(pack_vtx(v0), edge_point(v0, v1, d[0], d[1]),
                 edge_point(v0, v2, d[0], d[2]), 1'b1);
      end else if (!outside[1]) begin
        push_tri(pack_vtx(v1), edge_point(v1, v0, d[1], d[0]),
                 edge_point(v1, v2, d[1], d[2]), 1'b1);
      end else begin
        push_tri(pack_vtx(v2), edge_point(v2, v0, d[2], d[0]),
                 edge_point(v2, v1, d[2], d[1]), 1'b1);
      end
    end else if (n_out == 1) begin
      if (outside[0]) begin
        e0 = edge_point(v1, v0, d[1], d[0]);
        e1 = edge_point(v2, v0, d[2], d[0]);
        push_tri(e0, e1, pack_vtx(v1), 1'b0);
        push_tri(pack_vtx(v2), e1, pack_vtx(v1), 1'b1);
      end else if (outside[1]) begin
        e0 = edge_point(v0, v1, d[0], d[1]);
        e1 = edge_point(v2, v1, d[2], d[1]);
        push_tri(e0, e1, pack_vtx(v2), 1'b0);
        push_tri(pack_vtx(v0), e0, pack_vtx(v2), 1'b1);
      end else begin
        e0 = edge_point(v0, v2, d[0], d[2]);
        e1 = edge_point(v1, v2, d[1], d[2]);
        push_tri(e0, e1, pack_vtx(v0), 1'b0);
        push_tri(pack_vtx(v1), e1, pack_vtx(v0), 1'b1);
      end
    end
  endfunction

  // offer one triangle, predict it once taken
  task automatic send_tri(logic [TDATA_W-1:0] tri_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = tri_in;
    do @(posedge clk); while (!in_tready);
    clip_triangle(tri_in);
    @(negedge clk);
  endtask

  task automatic send_vertices(int ax, int ay, int az, int bx, int by, int bz,
                               int cx, int cy, int cz);
    send_tri({cz, cy, cx, bz, by, bx, az, ay, ax});
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (expected_tris.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write one plane register while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_NX:  plane_nx = longint'(value);
      REG_NY:  plane_ny = longint'(value);
      REG_NZ:  plane_nz = longint'(value);
      default: plane_d = longint'(value);
    endcase
  endtask

  task automatic set_plane(int nx, int ny, int nz, int d);
    wait_idle();
    write_reg(REG_NX, nx);
    write_reg(REG_NY, ny);
    write_reg(REG_NZ, nz);
    write_reg(REG_OFF, d);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0:       return int'($urandom);
      1:       return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      2:       return $urandom_range(32'h0100_0000) - 32'h0080_0000;
      default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  function automatic logic [TDATA_W-1:0] rand_tri();
    logic [TDATA_W-1:0] t;
    for (int i = 0; i < 9; i++) t[32*i +: 32] = rand_coord();
    return t;
  endfunction

  // reset plane z = 0: each position outside, on-plane points, extremes
  task automatic test_directed_clip_cases();
    int one = 32'h0001_0000;
    send_vertices(1, 2, one, 3, 4, 5, -6, 7, 8);
    send_vertices(1, 2, -one, 3, 4, 0, -6, 7, -8);
    send_vertices(one, 0, -one, 0, one, one, 0, 0, one);
    send_vertices(one, 0, one, 0, one, -one, 0, 0, one);
    send_vertices(one, 0, one, 0, one, one, 0, 0, -one);
    send_vertices(one, 0, one, 0, one, -one, 0, 0, -3 * one);
    send_vertices(one, 0, -one, 0, one, one, 0, 0, -3 * one);
    send_vertices(one, 0, -one, 0, one, -one, 0, 0, 7);
    send_vertices(one, 5, 0, 9, one, one, 0, 0, one);
    send_vertices(one, 5, 0, 9, one, one, 0, 0, 0);
    send_vertices(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_vertices(32'h8000_0000, 32'h7fff_ffff, 1, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000, -1, -1, 32'h7fff_ffff);
    send_vertices(-1, -1, -1, -1, -1, -1, -1, -1, -1);
    set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    for (int i = 0; i < 4; i++) send_tri(rand_tri());
    // zero normal: only the offset decides
    set_plane(0, 0, 0, 5);
    send_tri(rand_tri());
    set_plane(0, 0, 0, 0);
    send_tri(rand_tri());
    set_plane(0, 0, 0, -5);
    send_tri(rand_tri());
  endtask

  task automatic test_random_phases();
    int idle_tab[4] = '{0, 52, 0, 29};
    int stall_tab[4] = '{0, 0, 52, 29};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) set_plane(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      else set_plane(int'($urandom) >>> $urandom_range(16), int'($urandom) >>> $urandom_range(16),
                     int'($urandom) >>> $urandom_range(16), int'($urandom));
      send_idle_pct = idle_tab[ph % 4];
      recv_stall_pct = stall_tab[ph % 4];
      for (int i = 0; i < 210; i++) send_tri(rand_tri());
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    set_plane(0, 0, 32'h0001_0000, 0);
    hold_off_cycles = 300;
    for (int i = 0; i < 80; i++) send_tri(rand_tri());
  endtask

  // receiver: random stalls plus a counted hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    clip_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tris.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected triangle %h last %b", out_tdata, out_tlast);
      end else begin
        want = expected_tris.pop_front();
        for (int f = 0; f < 9; f++) begin
          if (out_tdata[32*f +: 32] !== want.tri_data[32*f +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("coord %0d: expected %h got %h", f, want.tri_data[32*f +: 32],
                       out_tdata[32*f +: 32]);
          end
        end
        if (out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("tlast: expected %b got %b", want.last, out_tlast);
        end
      end
    end
  end

  // abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_NX;
    cfg_data = '0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    quiet_cycles = 0;
    plane_nx = 0;
    plane_ny = 0;
    plane_nz = 64'sd65536;
    plane_d = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed_clip_cases();
    test_random_phases();
    test_output_backpressure();
    wait_idle();
    if (mismatches == 0 && expected_tris.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/tpc_pkg.sv
rtl/tpc_edge_lane.sv
rtl/triangle_plane_clipper.sv
tb/sv/triangle_plane_clipper_tb.sv
